// File: rtl/core/adnp_pkg.sv
// Shared types, constants and helpers for the decimal number parser.
`timescale 1ns / 1ps
package adnp_pkg;

  localparam int MAX_FRACTION_DIGITS = 8;
  localparam int MAX_INTEGER_DIGITS  = 9;
  localparam int MAX_EXPONENT_DIGITS = 3;

  localparam int INT_W   = $clog2(10 ** MAX_INTEGER_DIGITS);
  localparam int FRAC_W  = $clog2(10 ** MAX_FRACTION_DIGITS);
  localparam int EXPA_W  = $clog2(10 ** MAX_EXPONENT_DIGITS);
  localparam int P10_W   = $clog2(10 ** MAX_FRACTION_DIGITS + 1);
  localparam int FD_W    = 4;
  localparam int SIG_W   = 57;
  localparam int EXP_W   = 11;
  localparam int STAT_W  = 2;
  localparam int BYTE_W  = 8;

  localparam longint INT_LIMIT  = 10 ** MAX_INTEGER_DIGITS - 1;
  localparam longint FRAC_LIMIT = 10 ** MAX_FRACTION_DIGITS - 1;
  localparam longint EXPA_LIMIT = 10 ** MAX_EXPONENT_DIGITS - 1;

  localparam int CFG_W      = 20;
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_DECIMAL_MARK    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FIELD_SEPARATOR = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_VALUE_COUNT     = 2'd2;

  localparam logic [BYTE_W-1:0] RST_DECIMAL_MARK    = 8'd46;
  localparam logic [BYTE_W-1:0] RST_FIELD_SEPARATOR = 8'd44;
  localparam logic [CFG_W-1:0]  RST_VALUE_COUNT     = 20'd1;

  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2d;
  localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2b;
  localparam logic [BYTE_W-1:0] CH_E_UP   = 8'h45;
  localparam logic [BYTE_W-1:0] CH_E_LOW  = 8'h65;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FRAC  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EARLY = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVF   = 2'd3;

  localparam int OUT_TDATA_W = 72;

  // one finished field, handed from the front to the back
  typedef struct packed {
    logic                     neg;
    logic [INT_W-1:0]         int_acc;
    logic [FRAC_W-1:0]        frac_acc;
    logic [FD_W-1:0]          frac_digits;
    logic signed [EXP_W-1:0]  exponent;
    logic [STAT_W-1:0]        status;
    logic                     finished;
  } adnp_rec_t;

  function automatic logic [P10_W-1:0] pow10(input logic [FD_W-1:0] n);
    logic [P10_W-1:0] p;
    p = '0;
    for (int i = 0; i <= MAX_FRACTION_DIGITS; i++) begin
      if (n == FD_W'(i)) p = P10_W'(10 ** i);
    end
    return p;
  endfunction

endpackage

// File: rtl/core/adnp_front.sv
// Front end: config registers, byte classification and per-field accumulation.
`timescale 1ns / 1ps
module adnp_front #(
  parameter int COUNT_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [adnp_pkg::BYTE_W-1:0]       in_tdata,
  input  logic                              cfg_we,
  input  logic [adnp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [adnp_pkg::CFG_W-1:0]        cfg_data,
  output logic                              rec_valid,
  input  logic                              rec_ready,
  output adnp_pkg::adnp_rec_t               rec
);
  import adnp_pkg::*;

  localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  logic [BYTE_W-1:0]     dec_mark_r;
  logic [BYTE_W-1:0]     field_sep_r;
  logic [CFG_W-1:0]      value_count_r;

  logic [INT_W-1:0]      int_acc_r, int_acc_nxt;
  logic [FRAC_W-1:0]     frac_acc_r, frac_acc_nxt;
  logic [FD_W-1:0]       fd_r, fd_nxt;
  logic [EXPA_W-1:0]     exp_acc_r, exp_acc_nxt;
  logic                  mant_neg_r, mant_neg_nxt;
  logic                  exp_neg_r, exp_neg_nxt;
  logic                  in_frac_r, in_frac_nxt;
  logic                  in_exp_r, in_exp_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [COUNT_BITS-1:0] done_r, done_nxt;
  logic                  halted_r, halted_nxt;

  logic [INT_W+3:0]      int_v;
  logic [FRAC_W+3:0]     frac_v;
  logic [EXPA_W+3:0]     exp_v;
  logic [3:0]            digit;
  logic                  take;
  logic                  is_digit;
  logic                  is_term;
  logic                  err_frac;
  logic signed [EXP_W-1:0] e_val;
  logic                  push;
  adnp_rec_t             rec_d;

  assign in_tready = halted_r || rec_ready;
  assign take      = in_tvalid && in_tready && !halted_r;
  assign digit     = in_tdata[3:0];
  assign is_digit  = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
  assign is_term   = (in_tdata == field_sep_r) || (in_tdata == CH_LF) ||
                     (in_tdata == CH_CR) || (in_tdata == CH_NUL);
  assign err_frac  = fd_r > FD_W'(MAX_FRACTION_DIGITS);

  assign int_v  = (INT_W+4)'(int_acc_r) * (INT_W+4)'(10) + (INT_W+4)'(digit);
  assign frac_v = (FRAC_W+4)'(frac_acc_r) * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit);
  assign exp_v  = (EXPA_W+4)'(exp_acc_r) * (EXPA_W+4)'(10) + (EXPA_W+4)'(digit);

  always_comb begin
    e_val = '0;
    if (in_exp_r) begin
      e_val = exp_neg_r ? -$signed(EXP_W'(exp_acc_r)) : $signed(EXP_W'(exp_acc_r));
    end
  end

  always_comb begin
    int_acc_nxt  = int_acc_r;
    frac_acc_nxt = frac_acc_r;
    fd_nxt       = fd_r;
    exp_acc_nxt  = exp_acc_r;
    mant_neg_nxt = mant_neg_r;
    exp_neg_nxt  = exp_neg_r;
    in_frac_nxt  = in_frac_r;
    in_exp_nxt   = in_exp_r;
    ovf_nxt      = ovf_r;
    done_nxt     = done_r;
    halted_nxt   = halted_r;
    push         = 1'b0;
    rec_d        = '0;
    if (take) begin
      if (in_tdata == CH_MINUS) begin
        if (in_exp_r) exp_neg_nxt = 1'b1;
        else mant_neg_nxt = 1'b1;
      end else if (in_tdata == CH_PLUS) begin
        // sign plus carries no information
      end else if (in_tdata == CH_E_UP || in_tdata == CH_E_LOW) begin
        in_exp_nxt  = 1'b1;
        in_frac_nxt = 1'b0;
      end else if (is_digit) begin
        if (in_frac_r) begin
          if (fd_r < FD_W'(MAX_FRACTION_DIGITS)) begin
            if (frac_v > (FRAC_W+4)'(FRAC_LIMIT)) begin
              ovf_nxt      = 1'b1;
              frac_acc_nxt = FRAC_W'(FRAC_LIMIT);
            end else begin
              frac_acc_nxt = frac_v[FRAC_W-1:0];
            end
          end
          if (fd_r != '1) fd_nxt = fd_r + 1'b1;
        end else if (in_exp_r) begin
          if (exp_v > (EXPA_W+4)'(EXPA_LIMIT)) begin
            ovf_nxt     = 1'b1;
            exp_acc_nxt = EXPA_W'(EXPA_LIMIT);
          end else begin
            exp_acc_nxt = exp_v[EXPA_W-1:0];
          end
        end else begin
          if (int_v > (INT_W+4)'(INT_LIMIT)) begin
            ovf_nxt     = 1'b1;
            int_acc_nxt = INT_W'(INT_LIMIT);
          end else begin
            int_acc_nxt = int_v[INT_W-1:0];
          end
        end
      end else if (in_tdata == dec_mark_r) begin
        in_frac_nxt = 1'b1;
        in_exp_nxt  = 1'b0;
      end else if (is_term) begin
        push = 1'b1;
        if (err_frac || ovf_r) begin
          rec_d.status   = err_frac ? ST_FRAC : ST_OVF;
          rec_d.finished = 1'b1;
          halted_nxt     = 1'b1;
        end else begin
          done_nxt = (done_r != '1) ? done_r + 1'b1 : done_r;
          rec_d.neg         = mant_neg_r;
          rec_d.int_acc     = int_acc_r;
          rec_d.frac_acc    = frac_acc_r;
          rec_d.frac_digits = fd_r;
          rec_d.exponent    = e_val - $signed(EXP_W'(fd_r));
          rec_d.status      = ST_OK;
          if (in_tdata == CH_NUL) begin
            rec_d.finished = 1'b1;
            if (CMP_W'(done_nxt) < CMP_W'(value_count_r)) rec_d.status = ST_EARLY;
          end else begin
            rec_d.finished = CMP_W'(done_nxt) >= CMP_W'(value_count_r);
          end
          halted_nxt = rec_d.finished;
        end
        int_acc_nxt  = '0;
        frac_acc_nxt = '0;
        fd_nxt       = '0;
        exp_acc_nxt  = '0;
        mant_neg_nxt = 1'b0;
        exp_neg_nxt  = 1'b0;
        in_frac_nxt  = 1'b0;
        in_exp_nxt   = 1'b0;
        ovf_nxt      = 1'b0;
      end
    end
  end

  assign rec_valid = push;
  assign rec       = rec_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_mark_r    <= RST_DECIMAL_MARK;
      field_sep_r   <= RST_FIELD_SEPARATOR;
      value_count_r <= RST_VALUE_COUNT;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DECIMAL_MARK:    dec_mark_r    <= cfg_data[BYTE_W-1:0];
        REG_FIELD_SEPARATOR: field_sep_r   <= cfg_data[BYTE_W-1:0];
        REG_VALUE_COUNT:     value_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_acc_r  <= '0;
      frac_acc_r <= '0;
      fd_r       <= '0;
      exp_acc_r  <= '0;
      mant_neg_r <= 1'b0;
      exp_neg_r  <= 1'b0;
      in_frac_r  <= 1'b0;
      in_exp_r   <= 1'b0;
      ovf_r      <= 1'b0;
      done_r     <= '0;
      halted_r   <= 1'b0;
    end else begin
      int_acc_r  <= int_acc_nxt;
      frac_acc_r <= frac_acc_nxt;
      fd_r       <= fd_nxt;
      exp_acc_r  <= exp_acc_nxt;
      mant_neg_r <= mant_neg_nxt;
      exp_neg_r  <= exp_neg_nxt;
      in_frac_r  <= in_frac_nxt;
      in_exp_r   <= in_exp_nxt;
      ovf_r      <= ovf_nxt;
      done_r     <= done_nxt;
      halted_r   <= halted_nxt;
    end
  end

endmodule

// File: rtl/core/adnp_queue.sv
// Two-entry field queue between the front and back ends.
`timescale 1ns / 1ps
module adnp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  adnp_pkg::adnp_rec_t wr_rec,
  output logic                rd_valid,
  input  logic                rd_ready,
  output adnp_pkg::adnp_rec_t rd_rec
);
  import adnp_pkg::*;

  adnp_rec_t  entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = count_r != 2'd2;
  assign rd_valid = count_r != 2'd0;
  assign rd_rec   = entry_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) entry_r[wr_ptr_r] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= !wr_ptr_r;
      if (do_rd) rd_ptr_r <= !rd_ptr_r;
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/core/adnp_back.sv
// Back end: significand multiply-add pipeline and the output register.
`timescale 1ns / 1ps
module adnp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rec_valid,
  output logic                          rec_ready,
  input  adnp_pkg::adnp_rec_t           rec,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_neg,
  output logic [adnp_pkg::SIG_W-1:0]    out_sig,
  output logic signed [adnp_pkg::EXP_W-1:0] out_exp,
  output logic [adnp_pkg::STAT_W-1:0]   out_status,
  output logic                          out_fin
);
  import adnp_pkg::*;

  logic                    s1_valid_r;
  logic [INT_W+P10_W-1:0]  s1_mul_r;
  logic [FRAC_W-1:0]       s1_frac_r;
  logic                    s1_neg_r;
  logic signed [EXP_W-1:0] s1_exp_r;
  logic [STAT_W-1:0]       s1_status_r;
  logic                    s1_fin_r;

  logic                    o_valid_r;
  logic                    o_neg_r;
  logic [SIG_W-1:0]        o_sig_r;
  logic signed [EXP_W-1:0] o_exp_r;
  logic [STAT_W-1:0]       o_status_r;
  logic                    o_fin_r;

  logic                    o_en;
  logic                    s1_en;

  assign o_en      = !o_valid_r || out_ready;
  assign s1_en     = !s1_valid_r || o_en;
  assign rec_ready = s1_en;

  // stage 1: integer part scaled by 10^fraction_digits
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_mul_r    <= (INT_W+P10_W)'(rec.int_acc) * (INT_W+P10_W)'(pow10(rec.frac_digits));
      s1_frac_r   <= rec.frac_acc;
      s1_neg_r    <= rec.neg;
      s1_exp_r    <= rec.exponent;
      s1_status_r <= rec.status;
      s1_fin_r    <= rec.finished;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && o_en) begin
      o_sig_r    <= SIG_W'(s1_mul_r) + SIG_W'(s1_frac_r);
      o_neg_r    <= s1_neg_r;
      o_exp_r    <= s1_exp_r;
      o_status_r <= s1_status_r;
      o_fin_r    <= s1_fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      if (s1_en) s1_valid_r <= rec_valid;
      if (o_en)  o_valid_r  <= s1_valid_r;
    end
  end

  assign out_valid  = o_valid_r;
  assign out_neg    = o_neg_r;
  assign out_sig    = o_sig_r;
  assign out_exp    = o_exp_r;
  assign out_status = o_status_r;
  assign out_fin    = o_fin_r;

endmodule

// File: rtl/core/ascii_decimal_number_parser_core.sv
// Top level of the ASCII decimal number parser: front, queue and back end.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------------------
//  in_     | in  | in_tvalid / in_tready   | in_tdata: one text byte
//  out_    | out | out_tvalid / out_tready | tdata: sign, significand, exponent;
//          |     |                         | tuser: status; tlast: finished
//  cfg_    | in  | cfg_we                  | cfg_addr register index, cfg_data value
//
// One byte per cycle is taken while in_tready is high; the front accumulates each digit
// as its byte is taken. A terminator byte is written to the queue at its accepting edge,
// then passes the multiply stage and the output register to become a result.
// Reset is synchronous; after reset the block is ready at once, no clearing pass.
// in_tready drops only while the two-entry queue is full; after a finished
// result every byte is taken and dropped until reset.
`timescale 1ns / 1ps
module ascii_decimal_number_parser_core #(
  parameter int COUNT_BITS = 20
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,    // [7:0] data_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [adnp_pkg::OUT_TDATA_W-1:0]  out_tdata,   // [0] is_negative,
                                                         // [57:1] significand,
                                                         // [68:58] decimal_exponent
  output logic [adnp_pkg::STAT_W-1:0]       out_tuser,   // [1:0] status
  output logic                              out_tlast,   // finished
  input  logic                              cfg_we,
  input  logic [adnp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [adnp_pkg::CFG_W-1:0]        cfg_data
);
  import adnp_pkg::*;

  logic                    f_valid;
  logic                    f_ready;
  adnp_rec_t               f_rec;
  logic                    q_valid;
  logic                    q_ready;
  adnp_rec_t               q_rec;
  logic                    b_neg;
  logic [SIG_W-1:0]        b_sig;
  logic signed [EXP_W-1:0] b_exp;

  adnp_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .rec_valid (f_valid),
    .rec_ready (f_ready),
    .rec       (f_rec)
  );

  adnp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_rec   (f_rec),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_rec   (q_rec)
  );

  adnp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_valid  (q_valid),
    .rec_ready  (q_ready),
    .rec        (q_rec),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_neg    (b_neg),
    .out_sig    (b_sig),
    .out_exp    (b_exp),
    .out_status (out_tuser),
    .out_fin    (out_tlast)
  );

  assign out_tdata = {(OUT_TDATA_W - 1 - SIG_W - EXP_W)'(0), b_exp, b_sig, b_neg};

`ifndef NO_ASSERTIONS
  // nothing may follow the finished result
  a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid)
    else $error("result after finished transaction");

  a_error_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FRAC || out_tuser == ST_OVF) |->
      out_tdata == '0 && out_tlast)
    else $error("error result carries value bits or is not final");

  a_early_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_EARLY |-> out_tlast)
    else $error("early end result is not final");
`endif

endmodule

// File: sim/tb_ascii_decimal_number_parser_core.sv
// Self-checking testbench for the ASCII decimal number parser core.
`timescale 1ns / 1ps
module tb_ascii_decimal_number_parser_core;
  import adnp_pkg::*;

  localparam int COUNT_W      = 20;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES  = 240;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [29:0]        int_acc;
    logic [29:0]        frac_acc;
    logic [3:0]         frac_n;
    logic [9:0]         exp_acc;
    logic               mneg;
    logic               eneg;
    logic               in_frac;
    logic               in_exp;
    logic               ovf;
    logic [COUNT_W-1:0] done;
    logic               halted;
  } parse_state_t;

  typedef struct packed {
    logic                    neg;
    logic [SIG_W-1:0]        sig;
    logic [EXP_W-1:0]        dexp;
    logic [STAT_W-1:0]       status;
    logic                    fin;
  } value_rec_t;

  typedef enum int {
    END_COUNT, END_NUL_EARLY, END_NUL_EXACT, END_FRAC, END_INT_OVF,
    END_EXP_OVF, END_BOTH, END_LOWER, END_ZERO
  } ending_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;
  logic                   out_tlast;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_W-1:0]       cfg_data;

  // predictor copy of registers and parse state
  logic [7:0]         mark_cfg;
  logic [7:0]         sep_cfg;
  logic [COUNT_W-1:0] count_cfg;
  parse_state_t       num_st;
  value_rec_t         pending_values[$];
  value_rec_t         seen_want;

  int mismatch_count = 0;
  int results_seen   = 0;
  int bytes_sent     = 0;
  int burst_left     = 0;
  int hold_cycles    = 0;
  int cycle_count    = 0;
  int rx_mode        = 0;
  int rx_mode_left   = 0;
  int rx_tick        = 0;

  always #2ns clk = ~clk;

  ascii_decimal_number_parser_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  function automatic logic [29:0] push_digit(input logic [29:0] acc, input logic [7:0] b,
                                             input longint lim, output bit over);
    longint v;
    v = longint'(acc) * 10 + longint'(b - CH_ZERO);
    over = (v > lim);
    if (over) v = lim;
    return v[29:0];
  endfunction

  // one text byte through the parser; returns 1 when a value comes out
  function automatic bit parse_text_byte(input parse_state_t cur, input logic [7:0] b,
                                         output parse_state_t nxt, output value_rec_t r);
    bit                 over;
    parse_state_t       clean;
    longint             sig;
    longint             p;
    int                 ex;
    logic [COUNT_W-1:0] done;
    bit                 fin;
    logic [STAT_W-1:0]  st;
    nxt = cur;
    r = '0;
    if (cur.halted) return 0;
    if (b == CH_MINUS) begin
      if (cur.in_exp) nxt.eneg = 1'b1;
      else nxt.mneg = 1'b1;
      return 0;
    end
    if (b == CH_PLUS) return 0;
    if (b == CH_E_UP || b == CH_E_LOW) begin
      nxt.in_exp = 1'b1;
      nxt.in_frac = 1'b0;
      return 0;
    end
    if (b >= CH_ZERO && b <= CH_NINE) begin
      if (cur.in_frac) begin
        if (cur.frac_n < MAX_FRACTION_DIGITS) begin
          nxt.frac_acc = push_digit(cur.frac_acc, b, FRAC_LIMIT, over);
          if (over) nxt.ovf = 1'b1;
        end
        if (cur.frac_n != 4'd15) nxt.frac_n = cur.frac_n + 4'd1;
      end else if (cur.in_exp) begin
        nxt.exp_acc = 10'(push_digit({20'd0, cur.exp_acc}, b, EXPA_LIMIT, over));
        if (over) nxt.ovf = 1'b1;
      end else begin
        nxt.int_acc = push_digit(cur.int_acc, b, INT_LIMIT, over);
        if (over) nxt.ovf = 1'b1;
      end
      return 0;
    end
    if (b == mark_cfg) begin
      nxt.in_frac = 1'b1;
      nxt.in_exp = 1'b0;
      return 0;
    end
    if (!(b == sep_cfg || b == CH_LF || b == CH_CR || b == CH_NUL)) return 0;

    clean = '0;
    clean.done = cur.done;
    nxt = clean;
    if (cur.frac_n > MAX_FRACTION_DIGITS || cur.ovf) begin
      // errored value: all number fields forced to zero
      r.status = (cur.frac_n > MAX_FRACTION_DIGITS) ? ST_FRAC : ST_OVF;
      r.fin = 1'b1;
      nxt.halted = 1'b1;
      return 1;
    end
    p = 1;
    for (int i = 0; i < cur.frac_n; i++) p = p * 10;
    sig = longint'(cur.int_acc) * p + longint'(cur.frac_acc);
    ex = 0;
    if (cur.in_exp) ex = cur.eneg ? -int'(cur.exp_acc) : int'(cur.exp_acc);
    ex = ex - int'(cur.frac_n);
    done = cur.done;
    if (done != COUNT_MAX) done = done + 1'b1;
    nxt.done = done;
    st = ST_OK;
    fin = 1'b0;
    if (b == CH_NUL) begin
      fin = 1'b1;
      if (done < count_cfg) st = ST_EARLY;
    end else if (done >= count_cfg) begin
      fin = 1'b1;
    end
    r.neg = cur.mneg;
    r.sig = sig[SIG_W-1:0];
    r.dexp = ex[EXP_W-1:0];
    r.status = st;
    r.fin = fin;
    nxt.halted = fin;
    return 1;
  endfunction

  // true if the byte neither finishes the run nor leads to an error later
  function automatic bit byte_keeps_running(input logic [7:0] b);
    parse_state_t trial;
    value_rec_t   r;
    bit           has;
    has = parse_text_byte(num_st, b, trial, r);
    return !(has && r.fin) && !trial.ovf && (trial.frac_n <= MAX_FRACTION_DIGITS);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_values.size() == 0) begin
        report_mismatch("unexpected result, tdata", longint'(out_tdata[SIG_W:0]), 0);
      end else begin
        seen_want = pending_values.pop_front();
        if (out_tdata[0] !== seen_want.neg)
          report_mismatch("is_negative", out_tdata[0], seen_want.neg);
        if (out_tdata[SIG_W:1] !== seen_want.sig)
          report_mismatch("significand", out_tdata[SIG_W:1], seen_want.sig);
        if (out_tdata[SIG_W+EXP_W:SIG_W+1] !== seen_want.dexp)
          report_mismatch("decimal_exponent", longint'($signed(out_tdata[SIG_W+EXP_W:SIG_W+1])),
                          longint'($signed(seen_want.dexp)));
        if (out_tdata[OUT_TDATA_W-1:SIG_W+EXP_W+1] !== '0)
          report_mismatch("tdata padding", out_tdata[OUT_TDATA_W-1:SIG_W+EXP_W+1], 0);
        if (out_tuser !== seen_want.status)
          report_mismatch("status", out_tuser, seen_want.status);
        if (out_tlast !== seen_want.fin)
          report_mismatch("finished", out_tlast, seen_want.fin);
      end
      results_seen++;
    end
  end

  // receiver: shifting stall patterns, plus a long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_mode_left = $urandom_range(8, 80);
        end
        rx_mode_left--;
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 4) == 0);
          default: out_tready <= ((rx_tick % 4) != 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // one byte transaction; valid stays up across a burst
  task automatic send_byte(input logic [7:0] b);
    parse_state_t nxt;
    value_rec_t   r;
    int           gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (parse_text_byte(num_st, b, nxt, r)) pending_values.push_back(r);
    num_st = nxt;
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // replaces a byte that would end the run with a plain line end or a no-op
  task automatic send_safe(input logic [7:0] b);
    logic [7:0] v;
    v = b;
    if (!byte_keeps_running(v)) begin
      if (byte_keeps_running(CH_LF)) v = CH_LF;
      else if (byte_keeps_running(CH_CR)) v = CH_CR;
      else v = CH_PLUS;
    end
    send_byte(v);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_DECIMAL_MARK:    mark_cfg  = data[7:0];
      REG_FIELD_SEPARATOR: sep_cfg   = data[7:0];
      REG_VALUE_COUNT:     count_cfg = data[COUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_digit(input bit nines);
    return CH_ZERO + (nines ? 8'd9 : 8'($urandom_range(0, 9)));
  endfunction

  // mostly well-formed numbers in the current format, sometimes all nines
  task automatic send_random_field();
    bit nines;
    int n;
    nines = ($urandom_range(0, 19) == 0);
    if ($urandom_range(0, 3) == 0) send_safe(CH_MINUS);
    else if ($urandom_range(0, 7) == 0) send_safe(CH_PLUS);
    n = nines ? MAX_INTEGER_DIGITS : $urandom_range(0, MAX_INTEGER_DIGITS);
    repeat (n) send_safe(pick_digit(nines));
    if (nines || $urandom_range(0, 1)) begin
      send_safe(mark_cfg);
      n = nines ? MAX_FRACTION_DIGITS : $urandom_range(0, MAX_FRACTION_DIGITS);
      repeat (n) send_safe(pick_digit(nines));
    end
    if (nines || $urandom_range(0, 2) == 0) begin
      send_safe($urandom_range(0, 1) ? CH_E_UP : CH_E_LOW);
      if (nines || $urandom_range(0, 2) == 0) send_safe(CH_MINUS);
      else if ($urandom_range(0, 3) == 0) send_safe(CH_PLUS);
      n = nines ? MAX_EXPONENT_DIGITS : $urandom_range(0, MAX_EXPONENT_DIGITS);
      repeat (n) send_safe(pick_digit(nines));
    end
    // leave some fields unterminated so the next one runs into them
    if ($urandom_range(0, 9) != 0) begin
      case ($urandom_range(0, 3))
        0, 1: send_safe(sep_cfg);
        2: send_safe(CH_LF);
        default: send_safe(CH_CR);
      endcase
    end
  endtask

  task automatic test_directed_fields();
    write_reg(REG_VALUE_COUNT, COUNT_MAX);
    send_text("-12.5e+3,");
    send_text("7E-2\r");
    send_text("1e5.2\n");   // exponent dropped by the later mark
    send_text(",");
    send_byte(8'hff);
    wait_idle();
  endtask

  task automatic test_random_tables();
    int stop_at;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_DECIMAL_MARK, CFG_W'(8'h2e));
                 write_reg(REG_FIELD_SEPARATOR, CFG_W'(8'h2c)); end
        1: begin write_reg(REG_DECIMAL_MARK, CFG_W'(8'h2c));
                 write_reg(REG_FIELD_SEPARATOR, CFG_W'(8'h3b)); end
        2: begin write_reg(REG_DECIMAL_MARK, CFG_W'(CH_NUL));
                 write_reg(REG_FIELD_SEPARATOR, CFG_W'(8'hff)); end
        3: begin write_reg(REG_DECIMAL_MARK, CFG_W'(8'hff));
                 write_reg(REG_FIELD_SEPARATOR, CFG_W'(CH_NUL)); end
        4: begin write_reg(REG_DECIMAL_MARK, CFG_W'($urandom_range(0, 255)));
                 write_reg(REG_FIELD_SEPARATOR, CFG_W'($urandom_range(0, 255))); end
        default: begin write_reg(REG_DECIMAL_MARK, CFG_W'(CH_E_LOW));
                       write_reg(REG_FIELD_SEPARATOR, CFG_W'(8'h2e)); end
      endcase
      if (phase % 2 == 0) write_reg(REG_VALUE_COUNT, COUNT_MAX);
      else write_reg(REG_VALUE_COUNT, CFG_W'($urandom_range(5000, 1048575)));
      stop_at = bytes_sent + PHASE_BYTES;
      while (bytes_sent < stop_at) begin
        if ($urandom_range(0, 6) == 0)
          repeat ($urandom_range(1, 4)) send_safe(8'($urandom_range(0, 255)));
        else
          send_random_field();
      end
      wait_idle();
    end
  endtask

  task automatic test_output_backpressure();
    write_reg(REG_DECIMAL_MARK, CFG_W'(8'h2e));
    write_reg(REG_FIELD_SEPARATOR, CFG_W'(8'h2c));
    // close any field left open so the short values below stay clean
    send_safe(CH_LF);
    hold_cycles = HOLD_CYCLES;
    repeat (40) send_text("1,");
    wait_idle();
  endtask

  // the run can finish only once, so one way of finishing is picked per seed
  task automatic test_final_value();
    ending_t ending;
    ending = ending_t'($urandom_range(0, 8));
    case (ending)
      END_COUNT: begin
        write_reg(REG_VALUE_COUNT, CFG_W'(num_st.done + 3));
        send_text("1.5,-2e3,7\n");
      end
      END_NUL_EARLY: begin
        write_reg(REG_VALUE_COUNT, COUNT_MAX);
        send_text("12.5");
        send_byte(CH_NUL);
      end
      END_NUL_EXACT: begin
        write_reg(REG_VALUE_COUNT, CFG_W'(num_st.done + 1));
        send_text("3e-2");
        send_byte(CH_NUL);
      end
      END_FRAC:    send_text("0.123456789,");
      END_INT_OVF: send_text("1234567890,");
      END_EXP_OVF: send_text("1e1000\n");
      END_BOTH:    send_text("9999999999.999999999,");
      END_LOWER: begin
        write_reg(REG_VALUE_COUNT, CFG_W'(1));
        send_text("5,");
      end
      default: begin
        write_reg(REG_VALUE_COUNT, '0);
        send_text("-0.0\r");
      end
    endcase
    // halted: everything after this must be swallowed
    send_text("8,9\n");
    send_byte(CH_NUL);
    send_byte(8'hff);
    wait_idle();
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_data  <= '0;
    mark_cfg  = RST_DECIMAL_MARK;
    sep_cfg   = RST_FIELD_SEPARATOR;
    count_cfg = RST_VALUE_COUNT;
    num_st    = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_fields();
    test_random_tables();
    test_output_backpressure();
    test_final_value();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && pending_values.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
